/* hw/rtl/mrfp_pkg.sv */
// types, codes and reset values for the motor reply frame parser
package mrfp_pkg;

  // function codes of reply frames
  localparam logic [7:0] FN_SPEED        = 8'h35;
  localparam logic [7:0] FN_POSITION     = 8'h36;
  localparam logic [7:0] FN_POS_ERROR    = 8'h37;
  localparam logic [7:0] FN_STATUS       = 8'h3A;
  localparam logic [7:0] FN_REPLY_0A     = 8'h0A;
  localparam logic [7:0] FN_REPLY_0E     = 8'h0E;
  localparam logic [7:0] FN_REPLY_F3     = 8'hF3;
  localparam logic [7:0] FN_REPLY_F6     = 8'hF6;
  localparam logic [7:0] FN_REPLY_FD     = 8'hFD;
  localparam logic [7:0] FN_REPLY_FE     = 8'hFE;

  // sign byte value that marks a negative quantity
  localparam logic [7:0] SIGN_NEGATIVE   = 8'h01;

  // frame lengths in bytes
  localparam logic [3:0] LEN_NONE        = 4'd0;
  localparam logic [3:0] LEN_SHORT       = 4'd4;
  localparam logic [3:0] LEN_SPEED       = 4'd6;
  localparam logic [3:0] LEN_LONG        = 4'd8;

  // configuration register indexes
  localparam logic [2:0] REG_DEVICE_ADDRESS    = 3'd0;
  localparam logic [2:0] REG_REVERSE_SIGN      = 3'd1;
  localparam logic [2:0] REG_CHECK_BYTE        = 3'd2;
  localparam logic [2:0] REG_CODE_ACCEPTED     = 3'd3;
  localparam logic [2:0] REG_CODE_COMPLETED    = 3'd4;
  localparam logic [2:0] REG_CODE_PARAM_ERROR  = 3'd5;
  localparam logic [2:0] REG_CODE_FORMAT_ERROR = 3'd6;

  // configuration reset values
  localparam logic [7:0] RST_DEVICE_ADDRESS    = 8'd1;
  localparam logic [7:0] RST_CHECK_BYTE        = 8'd107;
  localparam logic [7:0] RST_CODE_ACCEPTED     = 8'd2;
  localparam logic [7:0] RST_CODE_COMPLETED    = 8'd159;
  localparam logic [7:0] RST_CODE_PARAM_ERROR  = 8'd226;
  localparam logic [7:0] RST_CODE_FORMAT_ERROR = 8'd238;

  typedef logic [7:0] byte_t;

  // frame length set by the function byte, zero for unknown codes
  function automatic logic [3:0] length_for(input byte_t fn);
    logic [3:0] len;
    unique case (fn) inside
      FN_SPEED:                  len = LEN_SPEED;
      FN_POSITION, FN_POS_ERROR: len = LEN_LONG;
      FN_REPLY_0A, FN_REPLY_0E, FN_STATUS, FN_REPLY_F3,
      FN_REPLY_F6, FN_REPLY_FD, FN_REPLY_FE: len = LEN_SHORT;
      default:                   len = LEN_NONE;
    endcase
    return len;
  endfunction

endpackage

/* hw/rtl/motor_reply_frame_parser.sv */
// Reply frame parser for a serial stepper drive. One received byte is taken per
// transfer and gives exactly one result in the next cycle. A new byte can be taken in
// every cycle, also in the cycle in which the previous result is taken, since the
// result register frees as it is taken. While a result is held off by out_stall the
// input is stalled. The whole hunt, collect, check and decode step for a byte is a
// single pass of logic between the frame state registers and the result register.
// frame_end and frame_ok flag the byte that closes a frame. The decoded values and
// the wrapping frame counters always show the latest state, in raw drive units
// (0.1 rpm, 0.1 degree, 0.01 degree).
module motor_reply_frame_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               frame_end,
  output logic               frame_ok,
  output logic [7:0]         function_code,
  output logic [7:0]         response_code,
  output logic signed [16:0] speed_value,
  output logic signed [32:0] position_value,
  output logic signed [32:0] position_error_value,
  output logic [7:0]         drive_status,
  output logic [31:0]        valid_count,
  output logic [31:0]        invalid_count
);

  // configuration
  mrfp_pkg::byte_t device_address;
  logic            reverse_sign;
  mrfp_pkg::byte_t check_byte;
  mrfp_pkg::byte_t code_accepted;
  mrfp_pkg::byte_t code_completed;
  mrfp_pkg::byte_t code_param_error;
  mrfp_pkg::byte_t code_format_error;

  // frame state
  logic [2:0]      byte_index, byte_index_next;
  logic [3:0]      frame_length, frame_length_next;
  mrfp_pkg::byte_t frame_store [8];
  logic            store_write;

  // decoded state
  mrfp_pkg::byte_t func_reg, func_reg_next;
  mrfp_pkg::byte_t resp_reg, resp_reg_next;
  logic [16:0]     speed_reg, speed_reg_next;
  logic [32:0]     position_reg, position_reg_next;
  logic [32:0]     position_error_reg, position_error_reg_next;
  mrfp_pkg::byte_t status_reg, status_reg_next;
  logic [31:0]     good_frames, good_frames_next;
  logic [31:0]     bad_frames, bad_frames_next;

  logic            end_next, ok_next;
  logic            accept;
  logic            negative;
  logic [16:0]     speed_mag;
  logic [32:0]     long_mag;
  mrfp_pkg::byte_t fn;
  logic [3:0]      len_found;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign fn        = frame_store[1];
  assign negative  = (frame_store[2] == mrfp_pkg::SIGN_NEGATIVE) ^ reverse_sign;
  assign speed_mag = {1'b0, frame_store[3], frame_store[4]};
  assign long_mag  = {1'b0, frame_store[3], frame_store[4], frame_store[5], frame_store[6]};
  assign len_found = mrfp_pkg::length_for(rx_byte);

  always_comb begin
    byte_index_next         = byte_index;
    frame_length_next       = frame_length;
    store_write             = 1'b0;
    func_reg_next           = func_reg;
    resp_reg_next           = resp_reg;
    speed_reg_next          = speed_reg;
    position_reg_next       = position_reg;
    position_error_reg_next = position_error_reg;
    status_reg_next         = status_reg;
    good_frames_next        = good_frames;
    bad_frames_next         = bad_frames;
    end_next                = 1'b0;
    ok_next                 = 1'b0;

    if (accept) begin
      if (byte_index == 3'd0) begin
        // hunt for the address byte
        if (rx_byte == device_address) begin
          store_write     = 1'b1;
          byte_index_next = 3'd1;
        end
      end else if (byte_index == 3'd1) begin
        frame_length_next = len_found;
        if (len_found == mrfp_pkg::LEN_NONE) begin
          // unknown function: drop, but an address byte restarts a frame
          byte_index_next = (rx_byte == device_address) ? 3'd1 : 3'd0;
        end else begin
          store_write     = 1'b1;
          byte_index_next = 3'd2;
        end
      end else begin
        store_write     = 1'b1;
        byte_index_next = byte_index + 3'd1;
        if (({1'b0, byte_index} + 4'd1) == frame_length) begin
          // incoming byte is the last one of the frame
          byte_index_next   = 3'd0;
          frame_length_next = mrfp_pkg::LEN_NONE;
          end_next          = 1'b1;
          if (frame_store[0] != device_address || rx_byte != check_byte) begin
            bad_frames_next = bad_frames + 32'd1;
          end else begin
            func_reg_next = fn;
            ok_next       = 1'b1;
            case (fn)
              mrfp_pkg::FN_SPEED:
                speed_reg_next = negative ? -speed_mag : speed_mag;
              mrfp_pkg::FN_POSITION:
                position_reg_next = negative ? -long_mag : long_mag;
              mrfp_pkg::FN_POS_ERROR:
                position_error_reg_next = negative ? -long_mag : long_mag;
              mrfp_pkg::FN_STATUS:
                status_reg_next = frame_store[2];
              default: begin
                // generic short reply carries a response code
                resp_reg_next = frame_store[2];
                if (frame_store[2] != code_accepted && frame_store[2] != code_completed &&
                    frame_store[2] != code_param_error &&
                    frame_store[2] != code_format_error) begin
                  ok_next = 1'b0;
                end
              end
            endcase
            if (ok_next) begin
              good_frames_next = good_frames + 32'd1;
            end else begin
              bad_frames_next = bad_frames + 32'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address    <= mrfp_pkg::RST_DEVICE_ADDRESS;
      reverse_sign      <= 1'b0;
      check_byte        <= mrfp_pkg::RST_CHECK_BYTE;
      code_accepted     <= mrfp_pkg::RST_CODE_ACCEPTED;
      code_completed    <= mrfp_pkg::RST_CODE_COMPLETED;
      code_param_error  <= mrfp_pkg::RST_CODE_PARAM_ERROR;
      code_format_error <= mrfp_pkg::RST_CODE_FORMAT_ERROR;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mrfp_pkg::REG_DEVICE_ADDRESS:    device_address    <= cfg_data;
        mrfp_pkg::REG_REVERSE_SIGN:      reverse_sign      <= cfg_data[0];
        mrfp_pkg::REG_CHECK_BYTE:        check_byte        <= cfg_data;
        mrfp_pkg::REG_CODE_ACCEPTED:     code_accepted     <= cfg_data;
        mrfp_pkg::REG_CODE_COMPLETED:    code_completed    <= cfg_data;
        mrfp_pkg::REG_CODE_PARAM_ERROR:  code_param_error  <= cfg_data;
        mrfp_pkg::REG_CODE_FORMAT_ERROR: code_format_error <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (store_write) begin
      frame_store[byte_index] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index         <= 3'd0;
      frame_length       <= mrfp_pkg::LEN_NONE;
      func_reg           <= '0;
      resp_reg           <= '0;
      speed_reg          <= '0;
      position_reg       <= '0;
      position_error_reg <= '0;
      status_reg         <= '0;
      good_frames        <= '0;
      bad_frames         <= '0;
      out_valid          <= 1'b0;
      frame_end          <= 1'b0;
      frame_ok           <= 1'b0;
    end else begin
      byte_index         <= byte_index_next;
      frame_length       <= frame_length_next;
      func_reg           <= func_reg_next;
      resp_reg           <= resp_reg_next;
      speed_reg          <= speed_reg_next;
      position_reg       <= position_reg_next;
      position_error_reg <= position_error_reg_next;
      status_reg         <= status_reg_next;
      good_frames        <= good_frames_next;
      bad_frames         <= bad_frames_next;
      if (accept) begin
        out_valid <= 1'b1;
        frame_end <= end_next;
        frame_ok  <= ok_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // decoded state only moves when a new result is loaded, so it doubles as payload
  assign function_code        = func_reg;
  assign response_code        = resp_reg;
  assign speed_value          = $signed(speed_reg);
  assign position_value       = $signed(position_reg);
  assign position_error_value = $signed(position_error_reg);
  assign drive_status         = status_reg;
  assign valid_count          = good_frames;
  assign invalid_count        = bad_frames;

endmodule
